// ===== sv/baro_sensor_compensation_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation core checker
// Clock and reset names are those of the core's ports.
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helpers of the barometric compensation core.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DIV_STAGES = 32;

    localparam logic [31:0] C_FINE_OFFSET = 32'd64000;
    localparam logic [31:0] C_RAW_FULL    = 32'd1048576;
    localparam logic [31:0] C_PRESS_MUL   = 32'd3125;
    localparam logic [31:0] C_DIV_BIAS    = 32'd32768;
    localparam logic [31:0] C_OUT_SCALE   = 32'd10000;
    localparam logic [31:0] C_ROUND       = 32'd128;

    // calibration registers as written over the bus
    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
    } t_cal;

    // per-request side information carried alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic        dz;
        logic        big;
    } t_side;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] zx16(input logic [15:0] x);
        return {16'b0, x};
    endfunction

endpackage

// ===== sv/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// Ten-stage temperature and pressure pre-division arithmetic.
// ----------------------------------------------------------------------------
module bsc_front import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cal        i_cal,
    input  logic        i_valid,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    output logic        o_valid,
    output logic [31:0] o_dividend,
    output logic [31:0] o_divisor,
    output t_side       o_side
);

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
    logic [9:0]  r_v;

    logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap, r7_ap, r8_ap;
    logic [31:0] r1_a, r1_d;
    logic [31:0] r2_m1, r2_dd;
    logic [31:0] r3_v1t, r3_m3;
    logic [31:0] r4_fine;
    logic [31:0] r5_temp, r5_pv1;
    logic [31:0] r6_temp, r6_sq, r6_m5, r6_m2;
    logic [31:0] r7_temp, r7_v2a, r7_m3b, r7_m5, r7_m2;
    logic [31:0] r8_temp, r8_v2, r8_v1c;
    logic [31:0] r9_temp, r9_mp1, r9_num;
    logic [31:0] r10_temp, r10_div, r10_pn;
    logic [31:0] q5;

    assign t1 = zx16(i_cal.temp[15:0]);
    assign t2 = sx16(i_cal.temp[31:16]);
    assign t3 = sx16(i_cal.temp[47:32]);
    assign p1 = zx16(i_cal.press_a[15:0]);
    assign p2 = sx16(i_cal.press_a[31:16]);
    assign p3 = sx16(i_cal.press_a[47:32]);
    assign p4 = sx16(i_cal.press_b[15:0]);
    assign p5 = sx16(i_cal.press_b[31:16]);
    assign p6 = sx16(i_cal.press_b[47:32]);

    assign q5 = asr(r5_pv1, 5'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[8:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // temperature
            r1_ap   <= i_raw_pressure;
            r1_a    <= {15'b0, i_raw_temperature[19:3]} - (t1 << 1);
            r1_d    <= {16'b0, i_raw_temperature[19:4]} - t1;
            r2_ap   <= r1_ap;
            r2_m1   <= r1_a * t2;
            r2_dd   <= r1_d * r1_d;
            r3_ap   <= r2_ap;
            r3_v1t  <= asr(r2_m1, 5'd11);
            r3_m3   <= asr(r2_dd, 5'd12) * t3;
            r4_ap   <= r3_ap;
            r4_fine <= r3_v1t + asr(r3_m3, 5'd14);
            r5_ap   <= r4_ap;
            r5_temp <= asr((r4_fine << 2) + r4_fine + C_ROUND, 5'd8);
            r5_pv1  <= asr(r4_fine, 5'd1) - C_FINE_OFFSET;
            // pressure
            r6_ap   <= r5_ap;
            r6_temp <= r5_temp;
            r6_sq   <= q5 * q5;
            r6_m5   <= r5_pv1 * p5;
            r6_m2   <= p2 * r5_pv1;
            r7_ap   <= r6_ap;
            r7_temp <= r6_temp;
            r7_v2a  <= asr(r6_sq, 5'd11) * p6;
            r7_m3b  <= p3 * asr(r6_sq, 5'd13);
            r7_m5   <= r6_m5;
            r7_m2   <= r6_m2;
            r8_ap   <= r7_ap;
            r8_temp <= r7_temp;
            r8_v2   <= asr(r7_v2a + (r7_m5 << 1), 5'd2) + (p4 << 16);
            r8_v1c  <= asr(asr(r7_m3b, 5'd3) + asr(r7_m2, 5'd1), 5'd18);
            r9_temp <= r8_temp;
            r9_mp1  <= (C_DIV_BIAS + r8_v1c) * p1;
            r9_num  <= (C_RAW_FULL - {12'b0, r8_ap}) - asr(r8_v2, 5'd12);
            r10_temp <= r9_temp;
            r10_div  <= asr(r9_mp1, 5'd15);
            r10_pn   <= r9_num * C_PRESS_MUL;
        end
    end

    // big values divide first and double afterwards
    assign o_valid     = r_v[9];
    assign o_divisor   = r10_div;
    assign o_side.temp = r10_temp;
    assign o_side.dz   = (r10_div == '0);
    assign o_side.big  = r10_pn[31];
    assign o_dividend  = r10_pn[31] ? r10_pn : (r10_pn << 1);

endmodule

// ===== sv/bsc_div.sv =====
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_div import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_quotient,
    output t_side       o_side
);

    logic [DIV_STAGES-1:0] r_v;
    logic [31:0] r_rem  [DIV_STAGES];
    logic [31:0] r_nq   [DIV_STAGES];
    logic [31:0] r_den  [DIV_STAGES];
    t_side       r_side [DIV_STAGES];
    logic [31:0] n_rem  [DIV_STAGES];
    logic [31:0] n_nq   [DIV_STAGES];

    // remainder shifts up, dividend bits leave the top of nq, quotient bits enter below
    always_comb begin
        logic [31:0] rem_in, nq_in, den_in;
        logic [32:0] trial;
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                rem_in = '0;
                nq_in  = i_dividend;
                den_in = i_divisor;
            end else begin
                rem_in = r_rem[j-1];
                nq_in  = r_nq[j-1];
                den_in = r_den[j-1];
            end
            trial = {rem_in, nq_in[31]};
            if (trial >= {1'b0, den_in}) begin
                n_rem[j] = 32'(trial - {1'b0, den_in});
                n_nq[j]  = {nq_in[30:0], 1'b1};
            end else begin
                n_rem[j] = trial[31:0];
                n_nq[j]  = {nq_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_rem[j] <= n_rem[j];
                r_nq[j]  <= n_nq[j];
                if (j == 0) begin
                    r_den[j]  <= i_divisor;
                    r_side[j] <= i_side;
                end else begin
                    r_den[j]  <= r_den[j-1];
                    r_side[j] <= r_side[j-1];
                end
            end
        end
    end

    assign o_valid    = r_v[DIV_STAGES-1];
    assign o_quotient = r_nq[DIV_STAGES-1];
    assign o_side     = r_side[DIV_STAGES-1];

endmodule

// ===== sv/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// Four-stage post-division pressure correction; last stage is the output register.
// ----------------------------------------------------------------------------
module bsc_back import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cal        i_cal,
    input  logic        i_valid,
    input  logic [31:0] i_quotient,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_scaled,
    output logic        o_divisor_zero
);

    logic [31:0] p7, p8, p9, p_in, x_in;
    logic [3:0]  r_v;

    logic [31:0] r1_p, r1_xx, r1_m8, r2_p, r2_v1, r2_v2, r3_sum;
    logic [31:0] r1_temp, r2_temp, r3_temp, r4_temp, r4_pres;
    logic        r1_dz, r2_dz, r3_dz, r4_dz;

    assign p7   = sx16(i_cal.press_c[15:0]);
    assign p8   = sx16(i_cal.press_c[31:16]);
    assign p9   = sx16(i_cal.press_c[47:32]);
    assign p_in = i_side.big ? (i_quotient << 1) : i_quotient;
    assign x_in = p_in >> 3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_temp <= i_side.temp;
            r1_dz   <= i_side.dz;
            r1_p    <= p_in;
            r1_xx   <= x_in * x_in;
            r1_m8   <= (p_in >> 2) * p8;
            r2_temp <= r1_temp;
            r2_dz   <= r1_dz;
            r2_p    <= r1_p;
            r2_v1   <= p9 * (r1_xx >> 13);
            r2_v2   <= asr(r1_m8, 5'd13);
            r3_temp <= r2_temp;
            r3_dz   <= r2_dz;
            r3_sum  <= r2_p + asr(asr(r2_v1, 5'd12) + r2_v2 + p7, 5'd4);
            r4_temp <= r3_temp;
            r4_dz   <= r3_dz;
            r4_pres <= r3_dz ? '0 : r3_sum * C_OUT_SCALE;
        end
    end

    assign o_valid             = r_v[3];
    assign o_temperature_centi = r4_temp;
    assign o_pressure_scaled   = r4_pres;
    assign o_divisor_zero      = r4_dz;

endmodule

// ===== sv/baro_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// Integer compensation of raw barometric pressure and temperature readings.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_valid / o_stall) carries one request: a raw 20-bit
//   pressure and a raw 20-bit temperature conversion. Output channel
//   (o_valid / i_stall) returns temperature in 0.01 degC, pressure in
//   Pa x 10000 (wrapping mod 2^32) and a flag for a zero pressure divisor.
//   Calibration sits in four 48-bit registers on the APB port at byte
//   addresses 0, 8, 16 and 24; write them only while no request is in flight.
//   From acceptance to o_valid a request passes 10 arithmetic stages,
//   32 divider stages (one quotient bit per stage) and 4 correction stages,
//   the last of which is the output register. The pipeline has no loops.
//   Throughput is one request per cycle unless a held result stalls it.
//   When a result waits under i_stall the whole pipeline freezes and
//   o_stall rises in the same cycle, so nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and clears the calibration.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core import bsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // request in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    // result out
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_scaled,
    output logic        o_divisor_zero
);

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    t_cal        r_cal;
    logic        wr_en, adv;
    logic        fr_valid, dv_valid;
    logic [31:0] fr_dividend, fr_divisor, dv_quotient, temp_out;
    t_side       fr_side, dv_side;

    // --- config registers ---
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:3])
                REG_TEMP:    r_cal.temp    <= pwdata[47:0];
                REG_PRESS_A: r_cal.press_a <= pwdata[47:0];
                REG_PRESS_B: r_cal.press_b <= pwdata[47:0];
                REG_PRESS_C: r_cal.press_c <= pwdata[47:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_TEMP:    prdata = {16'b0, r_cal.temp};
            REG_PRESS_A: prdata = {16'b0, r_cal.press_a};
            REG_PRESS_B: prdata = {16'b0, r_cal.press_b};
            REG_PRESS_C: prdata = {16'b0, r_cal.press_c};
        endcase
    end

    // --- flow control: pipeline moves unless a finished result is held ---
    assign adv     = ~(o_valid & i_stall);
    assign o_stall = ~adv;

    bsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (adv),
        .i_cal             (r_cal),
        .i_valid           (i_valid),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (fr_valid),
        .o_dividend        (fr_dividend),
        .o_divisor         (fr_divisor),
        .o_side            (fr_side)
    );

    bsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (fr_valid),
        .i_dividend (fr_dividend),
        .i_divisor  (fr_divisor),
        .i_side     (fr_side),
        .o_valid    (dv_valid),
        .o_quotient (dv_quotient),
        .o_side     (dv_side)
    );

    bsc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (adv),
        .i_cal               (r_cal),
        .i_valid             (dv_valid),
        .i_quotient          (dv_quotient),
        .i_side              (dv_side),
        .o_valid             (o_valid),
        .o_temperature_centi (temp_out),
        .o_pressure_scaled   (o_pressure_scaled),
        .o_divisor_zero      (o_divisor_zero)
    );

    assign o_temperature_centi = $signed(temp_out);

endmodule

// ===== sv/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
`include "baro_sensor_compensation_core_defines.svh"

module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_temperature_centi,
    input logic [31:0] o_pressure_scaled,
    input logic        o_divisor_zero
);

    // held result does not move
    `BSC_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_temperature_centi) && $stable(o_pressure_scaled) && $stable(o_divisor_zero), "held result changed")

    // a zero divisor forces zero pressure
    `BSC_ASSERT_IMP(a_dz_zero, o_valid && o_divisor_zero, o_pressure_scaled == 32'd0, "pressure not zero on zero divisor")

    // requests are refused only behind a held result
    `BSC_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without a held result")

    // pipeline comes out of reset empty
    `BSC_ASSERT_IMP(a_reset_empty, !$past(i_rst_n), !o_valid && !o_stall, "result present after reset")

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_temperature_centi (o_temperature_centi),
    .o_pressure_scaled   (o_pressure_scaled),
    .o_divisor_zero      (o_divisor_zero)
);

// ===== tb/sv/tb_baro_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation_core
// Self-checking bench for the barometric compensation core. A directed table
// runs first: the reset state, a known calibration, a zero divisor and corner
// coefficients. Random calibrations and raw readings follow. Every accepted
// request is predicted in 32-bit wrapping arithmetic, and each reading that
// comes out is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation_core;
    import bsc_pkg::*;

    localparam int LATENCY        = 46;   // acceptance to o_valid
    localparam int HOLD_CYCLES    = 300;  // long hold-off on the result side
    localparam int WATCHDOG_LIMIT = 4000; // cycles with no traffic at all
    localparam int N_PHASES       = 10;
    localparam int PHASE_LEN      = 128;
    localparam int N_DIR          = 29;

    // register index, byte address is index * 8
    typedef enum logic [1:0] {
        CAL_TEMP,
        CAL_PRESS_A,
        CAL_PRESS_B,
        CAL_PRESS_C
    } cal_reg_e;

    typedef enum logic [1:0] {
        ROW_WRITE,      // calibration write, pipeline drained first
        ROW_REQ,        // request, reading from the predictor
        ROW_REQ_FIXED   // request, reading typed into the table
    } row_kind_e;

    typedef struct packed {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic               dz;
    } reading_t;

    typedef struct packed {
        row_kind_e   kind;
        cal_reg_e    reg_idx;
        logic [63:0] wdata;
        logic [19:0] raw_p;
        logic [19:0] raw_t;
        reading_t    want;
    } dir_row_t;

    localparam reading_t NO_READING = '0;
    // zero coefficients: fine temperature 0, divisor 0
    localparam reading_t ZERO_CAL   = '{temp: 32'sd0, press: 32'd0, dz: 1'b1};

    // Directed table. The known calibration is the usual data sheet example
    // set; the all-ones writes also carry junk above bit 47.
    localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
        '{ROW_REQ_FIXED, CAL_TEMP,    64'h0, 20'h00000, 20'h00000, ZERO_CAL},
        '{ROW_REQ_FIXED, CAL_TEMP,    64'h0, 20'hFFFFF, 20'hFFFFF, ZERO_CAL},
        '{ROW_REQ_FIXED, CAL_TEMP,    64'h0, 20'h80000, 20'h7FFFF, ZERO_CAL},
        '{ROW_WRITE, CAL_TEMP,    64'h0000_FC18_6743_6B70, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_A, 64'h0000_0BD0_D643_8E7D, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_B, 64'h0000_FFF9_008C_0B27, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_C, 64'h0000_1770_C6F8_3C8C, 20'h0, 20'h0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h655AC, 20'h7EED0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h00000, 20'h00000, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'hFFFFF, 20'hFFFFF, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h00000, 20'hFFFFF, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'hFFFFF, 20'h00000, NO_READING},
        // P1 = 0: divisor zero, temperature still live
        '{ROW_WRITE, CAL_PRESS_A, 64'h0000_0BD0_D643_0000, 20'h0, 20'h0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h655AC, 20'h7EED0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h00001, 20'h80000, NO_READING},
        '{ROW_WRITE, CAL_TEMP,    64'hFFFF_FFFF_FFFF_FFFF, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_C, 64'hFFFF_FFFF_FFFF_FFFF, 20'h0, 20'h0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h655AC, 20'h7EED0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'hFFFFF, 20'h00000, NO_READING},
        // most positive and most negative lanes
        '{ROW_WRITE, CAL_TEMP,    64'h0000_8000_7FFF_FFFF, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_A, 64'h0000_7FFF_8000_FFFF, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_B, 64'h0000_8000_7FFF_8000, 20'h0, 20'h0, NO_READING},
        '{ROW_WRITE, CAL_PRESS_C, 64'h0000_7FFF_8000_7FFF, 20'h0, 20'h0, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h00000, 20'hFFFFF, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'hFFFFF, 20'h00000, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'h55555, 20'hAAAAA, NO_READING},
        '{ROW_REQ,       CAL_TEMP,    64'h0, 20'hAAAAA, 20'h55555, NO_READING}
    };

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic [19:0]        i_raw_pressure;
    logic [19:0]        i_raw_temperature;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_temperature_centi;
    logic [31:0]        o_pressure_scaled;
    logic               o_divisor_zero;

    // bench state
    reading_t    pending_readings [$];   // predictions awaiting the output
    logic [47:0] cal_temp, cal_press_a, cal_press_b, cal_press_c;
    int          n_err = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;         // random gaps and stalls
    bit          hold_req = 1'b0;        // ask the receiver for a long hold-off

    baro_sensor_compensation_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_raw_pressure      (i_raw_pressure),
        .i_raw_temperature   (i_raw_temperature),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_scaled   (o_pressure_scaled),
        .o_divisor_zero      (o_divisor_zero)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: 32-bit two's complement throughout, signed shifts arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [31:0] shr_arith(input logic [31:0] v, input int unsigned n);
        shr_arith = $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] x);
        sext16 = {{16{x[15]}}, x};
    endfunction

    function automatic reading_t compensate(input logic [19:0] raw_p,
                                            input logic [19:0] raw_t);
        logic [31:0] ap, at, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] v1, v2, d, fine, sq, q, p, prod;
        reading_t    r;
        ap = {12'b0, raw_p};
        at = {12'b0, raw_t};
        t1 = {16'b0, cal_temp[15:0]};
        t2 = sext16(cal_temp[31:16]);
        t3 = sext16(cal_temp[47:32]);
        p1 = {16'b0, cal_press_a[15:0]};
        p2 = sext16(cal_press_a[31:16]);
        p3 = sext16(cal_press_a[47:32]);
        p4 = sext16(cal_press_b[15:0]);
        p5 = sext16(cal_press_b[31:16]);
        p6 = sext16(cal_press_b[47:32]);
        p7 = sext16(cal_press_c[15:0]);
        p8 = sext16(cal_press_c[31:16]);
        p9 = sext16(cal_press_c[47:32]);
        r  = NO_READING;

        // temperature, fine resolution
        v1     = shr_arith(((at >> 3) - (t1 << 1)) * t2, 11);
        d      = (at >> 4) - t1;
        v2     = shr_arith(shr_arith(d * d, 12) * t3, 14);
        fine   = v1 + v2;
        r.temp = shr_arith(fine * 32'd5 + C_ROUND, 8);

        // pressure divisor
        v1 = shr_arith(fine, 1) - C_FINE_OFFSET;
        q  = shr_arith(v1, 2);
        sq = q * q;
        v2 = shr_arith(sq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = shr_arith(v2, 2) + (p4 << 16);
        v1 = shr_arith(shr_arith(p3 * shr_arith(sq, 13), 3) + shr_arith(p2 * v1, 1), 18);
        v1 = shr_arith((C_DIV_BIAS + v1) * p1, 15);

        if (v1 == 32'd0) begin
            r.dz = 1'b1;
        end else begin
            p = ((C_RAW_FULL - ap) - shr_arith(v2, 12)) * C_PRESS_MUL;
            // large values are divided before doubling
            if (p < 32'h8000_0000) begin
                q = p << 1;
                p = q / v1;
            end else begin
                q = p / v1;
                p = q << 1;
            end
            q       = p >> 3;
            prod    = q * q;
            v1      = shr_arith(p9 * (prod >> 13), 12);
            v2      = shr_arith((p >> 2) * p8, 13);
            p       = p + shr_arith(v1 + v2 + p7, 4);
            r.press = p * C_OUT_SCALE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Calibration port: write then read back, called at a falling edge
    // ------------------------------------------------------------------------
    task automatic write_cal(input cal_reg_e idx, input logic [63:0] val);
        logic [47:0] rb;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            CAL_TEMP:    cal_temp    = val[47:0];
            CAL_PRESS_A: cal_press_a = val[47:0];
            CAL_PRESS_B: cal_press_b = val[47:0];
            CAL_PRESS_C: cal_press_c = val[47:0];
        endcase
        // read-back, psel stays high into the next setup
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rb = prdata[47:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rb !== val[47:0]) begin
            $display("%0t: register %s read back expected %h got %h",
                     $time, idx.name(), val[47:0], rb);
            n_err++;
        end
        // idle gap so the next setup never lands on this edge
        @(negedge i_clk);
    endtask

    // drop valid and wait for every outstanding reading
    task automatic settle();
        i_valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Request side: offer one request, hold it until accepted
    // ------------------------------------------------------------------------
    task automatic push_request(input logic [19:0] rp, input logic [19:0] rt,
                                input bit fixed, input reading_t fixed_want);
        reading_t want;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_raw_pressure    = rp;
        i_raw_temperature = rt;
        want = fixed ? fixed_want : compensate(rp, rt);
        do @(posedge i_clk); while (o_stall);
        pending_readings.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] jitter(input int base, input int span);
        jitter = 16'(base - span + int'($urandom_range(0, 2 * span)));
    endfunction

    function automatic logic [15:0] corner_lane();
        case ($urandom_range(0, 4))
            0:       corner_lane = 16'h0000;
            1:       corner_lane = 16'h0001;
            2:       corner_lane = 16'h7FFF;
            3:       corner_lane = 16'h8000;
            default: corner_lane = 16'hFFFF;
        endcase
    endfunction

    // Calibration sets for a random phase:
    //   0 realistic, 1 raw random, 2 realistic with tiny P1, 3 corner lanes
    task automatic calibrate(input int mode);
        logic [47:0] tc, pa, pb, pc;
        tc = {jitter(-1000, 500), jitter(26435, 3000), jitter(27504, 3000)};
        pa = {jitter(3024, 500), jitter(-10685, 1000), jitter(36477, 3000)};
        pb = {jitter(-7, 10), jitter(140, 100), jitter(2855, 500)};
        pc = {jitter(6000, 500), jitter(-14600, 1000), jitter(15500, 1000)};
        case (mode)
            1: begin
                tc = {16'($urandom), 32'($urandom)};
                pa = {16'($urandom), 32'($urandom)};
                pb = {16'($urandom), 32'($urandom)};
                pc = {16'($urandom), 32'($urandom)};
            end
            2: pa[15:0] = 16'($urandom_range(0, 3));
            3: begin
                tc = {corner_lane(), corner_lane(), corner_lane()};
                pa = {corner_lane(), corner_lane(), corner_lane()};
                pb = {corner_lane(), corner_lane(), corner_lane()};
                pc = {corner_lane(), corner_lane(), corner_lane()};
            end
            default: ;
        endcase
        settle();
        // junk in the upper 16 bits must be ignored
        write_cal(CAL_TEMP,    {16'($urandom), tc});
        write_cal(CAL_PRESS_A, {16'($urandom), pa});
        write_cal(CAL_PRESS_B, {16'($urandom), pb});
        write_cal(CAL_PRESS_C, {16'($urandom), pc});
    endtask

    // ------------------------------------------------------------------------
    // Result side: short random stalls, or one long hold-off on request
    // ------------------------------------------------------------------------
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            i_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            i_stall  = 1'b0;
            hold_req = 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            i_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
            i_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each reading against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_readings
        reading_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: reading with none expected: temp %0d press %0d dz %0b",
                         $time, o_temperature_centi, o_pressure_scaled, o_divisor_zero);
                n_err++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_centi !== want.temp) begin
                    $display("%0t: temperature_centi expected %0d got %0d",
                             $time, want.temp, o_temperature_centi);
                    n_err++;
                end
                if (o_pressure_scaled !== want.press) begin
                    $display("%0t: pressure_scaled expected %0d got %0d",
                             $time, want.press, o_pressure_scaled);
                    n_err++;
                end
                if (o_divisor_zero !== want.dz) begin
                    $display("%0t: divisor_zero expected %0b got %0b",
                             $time, want.dz, o_divisor_zero);
                    n_err++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles with no request, reading or register access
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [19:0] rp, rt;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_valid           = 1'b0;
        i_raw_pressure    = '0;
        i_raw_temperature = '0;
        cal_temp          = '0;
        cal_press_a       = '0;
        cal_press_b       = '0;
        cal_press_c       = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            case (DIR_TAB[i].kind)
                ROW_WRITE: begin
                    settle();
                    write_cal(DIR_TAB[i].reg_idx, DIR_TAB[i].wdata);
                end
                ROW_REQ:
                    push_request(DIR_TAB[i].raw_p, DIR_TAB[i].raw_t, 1'b0, NO_READING);
                default:
                    push_request(DIR_TAB[i].raw_p, DIR_TAB[i].raw_t, 1'b1,
                                 DIR_TAB[i].want);
            endcase
        end

        // random phases, each under a fresh calibration
        for (int ph = 0; ph < N_PHASES; ph++) begin
            calibrate(ph % 4);
            if (ph == N_PHASES - 1) idle_on = 1'b0;   // last phase at full rate
            for (int n = 0; n < PHASE_LEN; n++) begin
                // stall the result side for a long stretch; the sender keeps
                // offering so the pipeline fills and o_stall rises
                if (ph == 1 && n == 40) hold_req = 1'b1;
                case ($urandom_range(0, 9))
                    0, 1: begin
                        rp = 20'($urandom);
                        rt = 20'($urandom);
                    end
                    2: begin
                        rp = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
                        rt = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
                    end
                    default: begin
                        rp = 20'($urandom_range(250000, 500000));
                        rt = 20'($urandom_range(440000, 560000));
                    end
                endcase
                push_request(rp, rt, 1'b0, NO_READING);
            end
        end

        i_valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        // catch any stray reading behind the last one
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
